// ===== sv/nec_pkg.sv =====
// Shared constants, types and the exp(-1) constant for the covariance core.
// No dependencies.
`default_nettype none

package nec_pkg;

   localparam int EXP_FRAC     = 30;
   localparam int TERM_W       = EXP_FRAC + 1;
   localparam int SERIES_TERMS = 16;
   localparam int FAR_SHIFT    = 10;
   localparam int RECIP_SHIFT  = 33;
   localparam int POW_BITS     = 5;
   localparam int POW_STAGES   = 31;

   localparam logic [0:0] REG_BETA_LOW  = 1'b0;
   localparam logic [0:0] REG_BETA_HIGH = 1'b1;

   typedef logic [TERM_W-1:0] term_type;

   typedef struct packed {
      logic eq;
      logic far;
   } nec_flags_type;

   localparam term_type Q_ONE  = {1'b1, {EXP_FRAC{1'b0}}};
   localparam term_type Q_HALF = {2'b01, {(EXP_FRAC-1){1'b0}}};

   // exp(-1) in Q.30 as the truncated 16-term series with floored terms gives it
   localparam term_type EXP_ONE = 31'd395007543;

endpackage

`default_nettype wire

// ===== sv/nec_req_if.sv =====
// Request channel: point pair item with valid/ready handshake.
// No dependencies.
`default_nettype none

interface nec_req_if #(
   parameter int INDEX_BITS = 20,
   parameter int FRAC_BITS  = 16
);
   logic                   valid;
   logic                   ready;
   logic [INDEX_BITS-1:0]  row_index;
   logic [INDEX_BITS-1:0]  col_index;
   logic [FRAC_BITS+1:0]   row_x;
   logic [FRAC_BITS+1:0]   row_y;
   logic [FRAC_BITS+1:0]   col_x;
   logic [FRAC_BITS+1:0]   col_y;

   modport source (output valid, row_index, col_index, row_x, row_y, col_x, col_y,
                   input ready);
   modport sink   (input valid, row_index, col_index, row_x, row_y, col_x, col_y,
                   output ready);
endinterface

`default_nettype wire

// ===== sv/nec_rsp_if.sv =====
// Response channel: one covariance entry item with valid/ready handshake.
// No dependencies.
`default_nettype none

interface nec_rsp_if #(
   parameter int FRAC_BITS = 16
);
   logic                 valid;
   logic                 ready;
   logic [FRAC_BITS:0]   kernel_value;

   modport source (output valid, kernel_value, input ready);
   modport sink   (input valid, kernel_value, output ready);
endinterface

`default_nettype wire

// ===== sv/nonstationary_exp_covariance_core.sv =====
// Nonstationary exponential covariance core: one matrix entry per point pair.
// Depends on nec_pkg, nec_req_if, nec_rsp_if, nec_div, nec_sqrt, nec_exp.
//
// req_chan carries an item of two point indices and both points' Q2.F
// coordinates; rsp_chan returns one Q1.F covariance entry per item, in order.
// csr_wr_en/csr_index/csr_wdata write beta_low (index 0) and beta_high
// (index 1); write them only while no item is in flight.
// The pipeline is four front stages (beta, squares, sums), a divider with
// one quotient bit per stage, a square root with one root bit per stage,
// 48 series stages and 31 exp(-1) stages for the exponential, and the
// output register.
// Throughput is one item per cycle. The whole pipeline advances together;
// when the output register holds an item the receiver has not taken, every
// stage holds and req_chan.ready drops, so nothing is lost or repeated.
// Reset (synchronous, active high) empties the pipeline and returns the
// betas to about 0.1 and 0.3.
`default_nettype none

module nonstationary_exp_covariance_core import nec_pkg::*; #(
   parameter int INDEX_BITS = 20,
   parameter int FRAC_BITS  = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   nec_req_if.sink               req_chan,
   nec_rsp_if.source             rsp_chan,
   input  logic                  csr_wr_en,
   input  logic [0:0]            csr_index,
   input  logic [FRAC_BITS-1:0]  csr_wdata
);

   localparam int F   = FRAC_BITS;
   localparam int CW  = F + 2;
   localparam int BW  = F + 2;
   localparam int PW  = 2 * F + 4;
   localparam int SW  = 2 * F + 5;
   localparam int NW  = 2 * F + 6;
   localparam int QW  = 2 * F + 10;
   localparam int RTW = QW / 2;
   localparam int TW  = 2 + F + 1;

   localparam logic [F-1:0] BETA_LOW_RESET  = F'((6554 * (2 ** F)) / 65536);
   localparam logic [F-1:0] BETA_HIGH_RESET = F'((19661 * (2 ** F)) / 65536);
   localparam logic [F:0]   ONE = {1'b1, {F{1'b0}}};
   localparam logic signed [PW-1:0] BHALF = PW'(2 ** (F - 1));
   localparam logic signed [PW-1:0] BONE  = PW'(2 ** F);

   function automatic logic [BW-1:0] beta_clamp(input logic signed [PW-1:0] t);
      logic [BW-1:0] b;
      if (t < BONE) begin
         b = BW'(1);
      end else begin
         b = t[2*F+1:F];
      end
      return b;
   endfunction

   logic [F-1:0] beta_low_ff;
   logic [F-1:0] beta_high_ff;
   logic         en;

   always_ff @(posedge clock) begin
      if (reset) begin
         beta_low_ff  <= BETA_LOW_RESET;
         beta_high_ff <= BETA_HIGH_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_BETA_LOW:  beta_low_ff  <= csr_wdata;
            REG_BETA_HIGH: beta_high_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // stage a: beta slope products
   logic signed [F:0]    slope;
   logic                 a_vld_ff;
   logic                 a_eq_ff;
   logic signed [PW-1:0] a_prod_r_ff, a_prod_c_ff;
   logic [CW-1:0]        a_rx_ff, a_ry_ff, a_cx_ff, a_cy_ff;

   assign slope = $signed({1'b0, beta_high_ff}) - $signed({1'b0, beta_low_ff});
   assign req_chan.ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else if (en) begin
         a_vld_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_eq_ff     <= req_chan.row_index == req_chan.col_index;
         a_prod_r_ff <= slope * $signed({1'b0, req_chan.row_x});
         a_prod_c_ff <= slope * $signed({1'b0, req_chan.col_x});
         a_rx_ff     <= req_chan.row_x;
         a_ry_ff     <= req_chan.row_y;
         a_cx_ff     <= req_chan.col_x;
         a_cy_ff     <= req_chan.col_y;
      end
   end

   // stage b: betas and coordinate distances
   logic signed [PW-1:0] base;
   logic                 b_vld_ff, b_eq_ff;
   logic [BW-1:0]        b_beta_r_ff, b_beta_c_ff;
   logic [CW-1:0]        b_dx_ff, b_dy_ff;

   assign base = $signed({4'b0000, beta_low_ff, {F{1'b0}}});

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= 1'b0;
      end else if (en) begin
         b_vld_ff <= a_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b_eq_ff     <= a_eq_ff;
         b_beta_r_ff <= beta_clamp(base + a_prod_r_ff + BHALF);
         b_beta_c_ff <= beta_clamp(base + a_prod_c_ff + BHALF);
         b_dx_ff     <= (a_rx_ff >= a_cx_ff) ? a_rx_ff - a_cx_ff : a_cx_ff - a_rx_ff;
         b_dy_ff     <= (a_ry_ff >= a_cy_ff) ? a_ry_ff - a_cy_ff : a_cy_ff - a_ry_ff;
      end
   end

   // stage c: squares and cross product
   logic              c_vld_ff, c_eq_ff;
   logic [2*BW-1:0]   c_bsq_r_ff, c_bsq_c_ff, c_bij_ff;
   logic [2*CW-1:0]   c_dxsq_ff, c_dysq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_vld_ff <= 1'b0;
      end else if (en) begin
         c_vld_ff <= b_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c_eq_ff    <= b_eq_ff;
         c_bsq_r_ff <= b_beta_r_ff * b_beta_r_ff;
         c_bsq_c_ff <= b_beta_c_ff * b_beta_c_ff;
         c_bij_ff   <= b_beta_r_ff * b_beta_c_ff;
         c_dxsq_ff  <= b_dx_ff * b_dx_ff;
         c_dysq_ff  <= b_dy_ff * b_dy_ff;
      end
   end

   // stage d: divisor, numerators and far test
   logic [SW-1:0]       den_in;
   logic [NW-1:0]       numd_in;
   logic                d_vld_ff;
   nec_flags_type       d_flags_ff;
   logic [SW-1:0]       d_den_ff;
   logic [1:0][NW-1:0]  d_num_ff;

   assign den_in  = SW'(c_bsq_r_ff) + SW'(c_bsq_c_ff);
   assign numd_in = (NW'(c_dxsq_ff) + NW'(c_dysq_ff)) << 1;

   always_ff @(posedge clock) begin
      if (reset) begin
         d_vld_ff <= 1'b0;
      end else if (en) begin
         d_vld_ff <= c_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_flags_ff.eq  <= c_eq_ff;
         d_flags_ff.far <= (SW+FAR_SHIFT)'(numd_in) >= {den_in, {FAR_SHIFT{1'b0}}};
         d_den_ff       <= den_in;
         d_num_ff[0]    <= numd_in;
         d_num_ff[1]    <= NW'(c_bij_ff) << 1;
      end
   end

   // divide, square root, exponential
   logic                 dv_valid;
   logic [1:0][QW-1:0]   dv_quo;
   nec_flags_type        dv_flags;
   logic                 sq_valid;
   logic [1:0][RTW-1:0]  sq_root;
   nec_flags_type        sq_flags;
   logic                 ex_valid;
   term_type             ex_val;
   logic [TW-1:0]        ex_tag;
   nec_flags_type        ex_flags;
   logic [F:0]           ex_coef;

   nec_div #(.NW(NW), .SW(SW), .QW(QW), .TAG_W(2)) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (d_vld_ff),
      .in_num    (d_num_ff),
      .in_den    (d_den_ff),
      .in_tag    (d_flags_ff),
      .out_valid (dv_valid),
      .out_quo   (dv_quo),
      .out_tag   (dv_flags)
   );

   nec_sqrt #(.QW(QW), .TAG_W(2)) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (dv_valid),
      .in_rad    (dv_quo),
      .in_tag    (dv_flags),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_tag   (sq_flags)
   );

   nec_exp #(.TAG_W(TW)) u_exp (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sq_valid),
      .in_t      ({sq_root[0][F-1:0], {(EXP_FRAC-F){1'b0}}}),
      .in_n      (sq_root[0][F+POW_BITS-1:F]),
      .in_tag    ({sq_flags, sq_root[1][F:0]}),
      .out_valid (ex_valid),
      .out_ex    (ex_val),
      .out_tag   (ex_tag)
   );

   assign ex_flags = ex_tag[TW-1:F+1];
   assign ex_coef  = ex_tag[F:0];

   // output register
   logic [F+31:0]  fmp;
   logic [F+1:0]   frnd;
   logic [F:0]     val_in;
   logic           rsp_valid_ff;
   logic [F:0]     rsp_kernel_ff;

   always_comb begin
      fmp  = (F+32)'(ex_coef) * (F+32)'(ex_val) + (F+32)'(Q_HALF);
      frnd = fmp[F+31:EXP_FRAC];
      if (ex_flags.eq) begin
         val_in = ONE;
      end else if (ex_flags.far) begin
         val_in = '0;
      end else if (frnd > (F+2)'(ONE)) begin
         val_in = ONE;
      end else begin
         val_in = frnd[F:0];
      end
   end

   assign en = !rsp_valid_ff || rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= ex_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_kernel_ff <= val_in;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.kernel_value = rsp_kernel_ff;

   a_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> rsp_chan.kernel_value <= ONE)
      else $error("kernel value above one");

   a_eq_one: assert property (@(posedge clock) disable iff (reset)
      (en && ex_valid && ex_flags.eq) |=> (rsp_valid_ff && rsp_kernel_ff == ONE))
      else $error("equal indices did not give one");

   a_far_zero: assert property (@(posedge clock) disable iff (reset)
      (en && ex_valid && !ex_flags.eq && ex_flags.far) |=> rsp_kernel_ff == '0)
      else $error("far pair did not give zero");

   a_front_hold: assert property (@(posedge clock) disable iff (reset)
      !en |=> ($stable(a_vld_ff) && $stable(d_vld_ff)))
      else $error("pipeline moved during stall");

endmodule

`default_nettype wire

// ===== sv/nec_div.sv =====
// Two-lane pipelined restoring divider, one quotient bit per stage, shared divisor.
// Depends on nec_pkg.
`default_nettype none

module nec_div import nec_pkg::*; #(
   parameter int NW    = 38,
   parameter int SW    = 37,
   parameter int QW    = 42,
   parameter int TAG_W = 2
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic [1:0][NW-1:0]   in_num,
   input  logic [SW-1:0]        in_den,
   input  logic [TAG_W-1:0]     in_tag,
   output logic                 out_valid,
   output logic [1:0][QW-1:0]   out_quo,
   output logic [TAG_W-1:0]     out_tag
);

   logic                vld_ff [QW+1];
   logic [1:0][SW-1:0]  rem_ff [QW+1];
   logic [1:0][QW-1:0]  quo_ff [QW+1];
   logic [1:0][QW-1:0]  ext_ff [QW+1];
   logic [SW-1:0]       den_ff [QW+1];
   logic [TAG_W-1:0]    tag_ff [QW+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int l = 0; l < 2; l++) begin
            rem_ff[0][l] <= SW'(in_num[l] >> FAR_SHIFT);
            ext_ff[0][l] <= {in_num[l][FAR_SHIFT-1:0], {(QW-FAR_SHIFT){1'b0}}};
            quo_ff[0][l] <= '0;
         end
         den_ff[0] <= in_den;
         tag_ff[0] <= in_tag;
      end
   end

   for (genvar i = 1; i <= QW; i++) begin : g_step
      logic [1:0][SW:0]    rs;
      logic [1:0][SW-1:0]  rem_in;
      logic [1:0][QW-1:0]  quo_in;
      logic [1:0][QW-1:0]  ext_in;

      always_comb begin
         for (int l = 0; l < 2; l++) begin
            rs[l]     = {rem_ff[i-1][l], ext_ff[i-1][l][QW-1]};
            ext_in[l] = {ext_ff[i-1][l][QW-2:0], 1'b0};
            if (rs[l] >= {1'b0, den_ff[i-1]}) begin
               rem_in[l] = SW'(rs[l] - {1'b0, den_ff[i-1]});
               quo_in[l] = {quo_ff[i-1][l][QW-2:0], 1'b1};
            end else begin
               rem_in[l] = rs[l][SW-1:0];
               quo_in[l] = {quo_ff[i-1][l][QW-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (en) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i] <= rem_in;
            quo_ff[i] <= quo_in;
            ext_ff[i] <= ext_in;
            den_ff[i] <= den_ff[i-1];
            tag_ff[i] <= tag_ff[i-1];
         end
      end
   end

   assign out_valid = vld_ff[QW];
   assign out_quo   = quo_ff[QW];
   assign out_tag   = tag_ff[QW];

endmodule

`default_nettype wire

// ===== sv/nec_sqrt.sv =====
// Two-lane pipelined integer square root, one root bit per stage.
// Depends on nec_pkg.
`default_nettype none

module nec_sqrt import nec_pkg::*; #(
   parameter int QW    = 42,
   parameter int TAG_W = 2
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  logic [1:0][QW-1:0]    in_rad,
   input  logic [TAG_W-1:0]      in_tag,
   output logic                  out_valid,
   output logic [1:0][QW/2-1:0]  out_root,
   output logic [TAG_W-1:0]      out_tag
);

   localparam int RTW = QW / 2;
   localparam int RMW = RTW + 2;

   logic                 vld_ff  [RTW+1];
   logic [1:0][QW-1:0]   rad_ff  [RTW+1];
   logic [1:0][RMW-1:0]  rem_ff  [RTW+1];
   logic [1:0][RTW-1:0]  root_ff [RTW+1];
   logic [TAG_W-1:0]     tag_ff  [RTW+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rad_ff[0]  <= in_rad;
         rem_ff[0]  <= '0;
         root_ff[0] <= '0;
         tag_ff[0]  <= in_tag;
      end
   end

   for (genvar i = 1; i <= RTW; i++) begin : g_step
      logic [1:0][RMW+1:0]  r2;
      logic [1:0][RMW+1:0]  trial;
      logic [1:0][RMW-1:0]  rem_in;
      logic [1:0][RTW-1:0]  root_in;
      logic [1:0][QW-1:0]   rad_in;

      always_comb begin
         for (int l = 0; l < 2; l++) begin
            r2[l]     = {rem_ff[i-1][l], rad_ff[i-1][l][QW-1:QW-2]};
            trial[l]  = (RMW+2)'({root_ff[i-1][l], 2'b01});
            rad_in[l] = {rad_ff[i-1][l][QW-3:0], 2'b00};
            if (r2[l] >= trial[l]) begin
               rem_in[l]  = RMW'(r2[l] - trial[l]);
               root_in[l] = {root_ff[i-1][l][RTW-2:0], 1'b1};
            end else begin
               rem_in[l]  = RMW'(r2[l]);
               root_in[l] = {root_ff[i-1][l][RTW-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (en) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rad_ff[i]  <= rad_in;
            rem_ff[i]  <= rem_in;
            root_ff[i] <= root_in;
            tag_ff[i]  <= tag_ff[i-1];
         end
      end
   end

   assign out_valid = vld_ff[RTW];
   assign out_root  = root_ff[RTW];
   assign out_tag   = tag_ff[RTW];

endmodule

`default_nettype wire

// ===== sv/nec_exp.sv =====
// Pipelined exp(-x): truncated series on the fraction, then one stage per
// integer step multiplying by exp(-1). Depends on nec_pkg.
`default_nettype none

module nec_exp import nec_pkg::*; #(
   parameter int TAG_W = 2
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic [EXP_FRAC-1:0]  in_t,
   input  logic [POW_BITS-1:0]  in_n,
   input  logic [TAG_W-1:0]     in_tag,
   output logic                 out_valid,
   output term_type             out_ex,
   output logic [TAG_W-1:0]     out_tag
);

   localparam int SER_ST = 3 * SERIES_TERMS;
   localparam int NST    = 1 + SER_ST + POW_STAGES;

   typedef struct packed {
      logic [EXP_FRAC-1:0]  t;
      logic [POW_BITS-1:0]  n;
      logic [TAG_W-1:0]     tag;
      term_type             sum;
      term_type             term;
      logic [63:0]          wide;
   } stage_type;

   logic       vld_ff [NST];
   stage_type  st_ff  [NST];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         st_ff[0].t    <= in_t;
         st_ff[0].n    <= in_n;
         st_ff[0].tag  <= in_tag;
         st_ff[0].sum  <= Q_ONE;
         st_ff[0].term <= Q_ONE;
         st_ff[0].wide <= '0;
      end
   end

   for (genvar j = 1; j < NST; j++) begin : g_st
      stage_type st_in;

      if (j <= SER_ST) begin : g_ser
         localparam int K     = (j + 2) / 3;
         localparam int PH    = (j - 1) % 3;
         localparam bit POW2  = (K & (K - 1)) == 0;
         localparam bit ODD_K = (K % 2) == 1;
         localparam int LOGK  = $clog2(K);
         localparam logic [31:0] RECIP = 32'((64'd1 << RECIP_SHIFT) / K);

         if (PH == 0) begin : g_mul
            logic [TERM_W+EXP_FRAC-1:0] mp;
            always_comb begin
               st_in      = st_ff[j-1];
               mp         = (TERM_W+EXP_FRAC)'(st_ff[j-1].term) *
                            (TERM_W+EXP_FRAC)'(st_ff[j-1].t);
               st_in.term = mp[TERM_W+EXP_FRAC-1:EXP_FRAC];
            end
         end else if (PH == 1) begin : g_rcp
            always_comb begin
               st_in = st_ff[j-1];
               if (!POW2) begin
                  st_in.wide = 64'(st_ff[j-1].term) * 64'(RECIP);
               end
            end
         end else begin : g_quo
            term_type q;
            if (POW2) begin : g_shift
               always_comb begin
                  q = st_ff[j-1].term >> LOGK;
               end
            end else begin : g_corr
               term_type q0;
               term_type rr;
               always_comb begin
                  q0 = st_ff[j-1].wide[63:RECIP_SHIFT];
                  rr = st_ff[j-1].term - TERM_W'(q0 * K);
                  q  = (rr >= TERM_W'(K)) ? q0 + 1'b1 : q0;
               end
            end
            always_comb begin
               st_in      = st_ff[j-1];
               st_in.term = q;
               if (ODD_K) begin
                  st_in.sum = st_ff[j-1].sum - q;
               end else begin
                  st_in.sum = st_ff[j-1].sum + q;
               end
            end
         end
      end else begin : g_pow
         localparam int P = j - SER_ST - 1;
         logic [2*TERM_W-1:0] mp;
         always_comb begin
            st_in = st_ff[j-1];
            mp    = (2*TERM_W)'(st_ff[j-1].sum) * (2*TERM_W)'(EXP_ONE) +
                    (2*TERM_W)'(Q_HALF);
            if (st_ff[j-1].n > POW_BITS'(P)) begin
               st_in.sum = mp[TERM_W+EXP_FRAC-1:EXP_FRAC];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[j] <= 1'b0;
         end else if (en) begin
            vld_ff[j] <= vld_ff[j-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            st_ff[j] <= st_in;
         end
      end
   end

   assign out_valid = vld_ff[NST-1];
   assign out_ex    = st_ff[NST-1].sum;
   assign out_tag   = st_ff[NST-1].tag;

endmodule

`default_nettype wire
